FILE: hdl/obfn_pkg.sv
// shared widths for the orthonormal basis block
`timescale 1ns / 1ps

package obfn_pkg;

    localparam int OUT_W  = 16;
    localparam int MAG_W  = 16;
    localparam int SQ_W   = 32;
    localparam int PROD_W = 64;
    localparam int N_OUT  = 9;

    // result order: u_x u_y u_z v_x v_y v_z w_x w_y w_z
    localparam int IDX_UX = 0;
    localparam int IDX_UY = 1;
    localparam int IDX_UZ = 2;
    localparam int IDX_VX = 3;
    localparam int IDX_VY = 4;
    localparam int IDX_VZ = 5;
    localparam int IDX_WX = 6;
    localparam int IDX_WY = 7;
    localparam int IDX_WZ = 8;

    typedef logic [N_OUT-1:0] sign_vec_t;
    typedef logic [OUT_W-1:0] comp_t;

endpackage

FILE: hdl/orthonormal_basis_from_normal.sv
// orthonormal frame u, v, w from one integer normal, fully pipelined
//
//  channel | signals                          | direction | transfer when
//  in      | normal_x/y/z, in_valid, in_stall | into blk  | in_valid & !in_stall
//  out     | u_*, v_*, w_*, zero_normal,      | out of    | out_valid & !out_stall
//          | out_valid, out_stall             |   blk     |
//
//  one transfer per cycle in each direction while no stall is set; data passes
//  the front end, then the FRAC_BITS + 2 steps of the root lanes
//  reset clears only valid bits, the pipeline is empty after reset
//  a stall on out fills a two-entry output buffer; in_stall is its full flag,
//  and the whole pipeline holds while it is set
`timescale 1ns / 1ps

module orthonormal_basis_from_normal #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] u_x,
    output logic signed [15:0] u_y,
    output logic signed [15:0] u_z,
    output logic signed [15:0] v_x,
    output logic signed [15:0] v_y,
    output logic signed [15:0] v_z,
    output logic signed [15:0] w_x,
    output logic signed [15:0] w_y,
    output logic signed [15:0] w_z,
    output logic        zero_normal
);

    localparam int NS = FRAC_BITS + 2;
    localparam int QW = NS + 1;
    localparam int MW = obfn_pkg::MAG_W;
    localparam int SW = obfn_pkg::SQ_W;
    localparam int PW = obfn_pkg::PROD_W;
    localparam int NO = obfn_pkg::N_OUT;
    localparam int OW = obfn_pkg::OUT_W;

    logic adv;

    // stage 1
    logic          v1_reg;
    logic [MW-1:0] ax_reg, ay_reg, az_reg;
    logic [2:0]    neg_reg;

    // stage 2
    logic          v2_reg;
    logic [SW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SW-1:0] pxy_reg, pxz_reg, pyz_reg;
    logic          axis2_reg, zero2_reg;
    obfn_pkg::sign_vec_t sgn2_reg;

    // stage 3
    logic          v3_reg;
    logic [SW-1:0] s3_reg, s23_reg;
    logic [SW-1:0] wcx3_reg, wcy3_reg, wcz3_reg;
    logic [SW-1:0] vcx3_reg, vcy3_reg, vcz3_reg;
    logic [SW-1:0] pxy3_reg, pxz3_reg, pyz3_reg;
    logic          axis3_reg, zero3_reg;
    obfn_pkg::sign_vec_t sgn3_reg;

    // stage 4
    logic          v4_reg;
    logic [PW-1:0] du_reg;
    logic [PW-1:0] ucx_reg, ucy_reg, ucz_reg;
    logic [SW-1:0] s4_reg, s24_reg;
    logic [SW-1:0] wcx4_reg, wcy4_reg, wcz4_reg;
    logic [SW-1:0] vcx4_reg, vcy4_reg, vcz4_reg;
    logic          zero4_reg;
    obfn_pkg::sign_vec_t sgn4_reg;

    // flags that ride alongside the root lanes
    logic                dly_vld_reg  [NS];
    logic                dly_zero_reg [NS];
    obfn_pkg::sign_vec_t dly_sgn_reg  [NS];

    // output register and skid
    logic                out_vld_reg, skid_vld_reg;
    obfn_pkg::comp_t     res_reg  [NO];
    obfn_pkg::comp_t     skid_reg [NO];
    logic                res_zero_reg, skid_zero_reg;

    logic [PW-1:0]       lane_c2 [NO];
    logic [PW-1:0]       lane_d  [NO];
    logic [NS-1:0]       lane_m  [NO];
    obfn_pkg::comp_t     tail    [NO];

    logic [MW-1:0] ax_next, ay_next, az_next;
    logic          axis_x;
    logic [SW-1:0] s2_next;
    logic [SW-1:0] opx, opy, opz;
    logic          out_free;

    assign adv      = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    assign ax_next = normal_x[15] ? MW'(-normal_x) : MW'(normal_x);
    assign ay_next = normal_y[15] ? MW'(-normal_y) : MW'(normal_y);
    assign az_next = normal_z[15] ? MW'(-normal_z) : MW'(normal_z);

    assign axis_x  = !(ay_reg > ax_reg) && !(az_reg > ax_reg);
    assign s2_next = axis2_reg ? (sqx_reg + sqz_reg) : (sqy_reg + sqz_reg);

    assign opx = axis3_reg ? pxy3_reg : s23_reg;
    assign opy = axis3_reg ? s23_reg  : pxy3_reg;
    assign opz = axis3_reg ? pyz3_reg : pxz3_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                dly_vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            dly_vld_reg[0] <= v4_reg;
            for (int i = 1; i < NS; i++)
            begin
                dly_vld_reg[i] <= dly_vld_reg[i-1];
            end
        end
    end

    // front end datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            az_reg  <= az_next;
            neg_reg <= {normal_z[15], normal_y[15], normal_x[15]};

            sqx_reg   <= SW'(ax_reg) * SW'(ax_reg);
            sqy_reg   <= SW'(ay_reg) * SW'(ay_reg);
            sqz_reg   <= SW'(az_reg) * SW'(az_reg);
            pxy_reg   <= SW'(ax_reg) * SW'(ay_reg);
            pxz_reg   <= SW'(ax_reg) * SW'(az_reg);
            pyz_reg   <= SW'(ay_reg) * SW'(az_reg);
            axis2_reg <= axis_x;
            zero2_reg <= (ax_reg == '0) && (ay_reg == '0) && (az_reg == '0);
            sgn2_reg[obfn_pkg::IDX_WX] <= neg_reg[0];
            sgn2_reg[obfn_pkg::IDX_WY] <= neg_reg[1];
            sgn2_reg[obfn_pkg::IDX_WZ] <= neg_reg[2];
            if (axis_x)
            begin
                sgn2_reg[obfn_pkg::IDX_VX] <= !neg_reg[2] && (az_reg != '0);
                sgn2_reg[obfn_pkg::IDX_VY] <= 1'b0;
                sgn2_reg[obfn_pkg::IDX_VZ] <= neg_reg[0];
                sgn2_reg[obfn_pkg::IDX_UX] <= (neg_reg[0] == neg_reg[1])
                                              && (ax_reg != '0) && (ay_reg != '0);
                sgn2_reg[obfn_pkg::IDX_UY] <= 1'b0;
                sgn2_reg[obfn_pkg::IDX_UZ] <= (neg_reg[1] == neg_reg[2])
                                              && (ay_reg != '0) && (az_reg != '0);
            end
            else
            begin
                sgn2_reg[obfn_pkg::IDX_VX] <= 1'b0;
                sgn2_reg[obfn_pkg::IDX_VY] <= neg_reg[2];
                sgn2_reg[obfn_pkg::IDX_VZ] <= !neg_reg[1] && (ay_reg != '0);
                sgn2_reg[obfn_pkg::IDX_UX] <= 1'b0;
                sgn2_reg[obfn_pkg::IDX_UY] <= (neg_reg[0] == neg_reg[1])
                                              && (ax_reg != '0) && (ay_reg != '0);
                sgn2_reg[obfn_pkg::IDX_UZ] <= (neg_reg[0] == neg_reg[2])
                                              && (ax_reg != '0) && (az_reg != '0);
            end

            s3_reg    <= sqx_reg + sqy_reg + sqz_reg;
            s23_reg   <= s2_next;
            wcx3_reg  <= sqx_reg;
            wcy3_reg  <= sqy_reg;
            wcz3_reg  <= sqz_reg;
            vcx3_reg  <= axis2_reg ? sqz_reg : '0;
            vcy3_reg  <= axis2_reg ? '0 : sqz_reg;
            vcz3_reg  <= axis2_reg ? sqx_reg : sqy_reg;
            pxy3_reg  <= pxy_reg;
            pxz3_reg  <= pxz_reg;
            pyz3_reg  <= pyz_reg;
            axis3_reg <= axis2_reg;
            zero3_reg <= zero2_reg;
            sgn3_reg  <= sgn2_reg;

            du_reg    <= PW'(s23_reg) * PW'(s3_reg);
            ucx_reg   <= PW'(opx) * PW'(opx);
            ucy_reg   <= PW'(opy) * PW'(opy);
            ucz_reg   <= PW'(opz) * PW'(opz);
            s4_reg    <= s3_reg;
            s24_reg   <= s23_reg;
            wcx4_reg  <= wcx3_reg;
            wcy4_reg  <= wcy3_reg;
            wcz4_reg  <= wcz3_reg;
            vcx4_reg  <= vcx3_reg;
            vcy4_reg  <= vcy3_reg;
            vcz4_reg  <= vcz3_reg;
            zero4_reg <= zero3_reg;
            sgn4_reg  <= sgn3_reg;

            dly_zero_reg[0] <= zero4_reg;
            dly_sgn_reg[0]  <= sgn4_reg;
            for (int i = 1; i < NS; i++)
            begin
                dly_zero_reg[i] <= dly_zero_reg[i-1];
                dly_sgn_reg[i]  <= dly_sgn_reg[i-1];
            end
        end
    end

    always_comb
    begin
        lane_c2[obfn_pkg::IDX_UX] = ucx_reg;
        lane_c2[obfn_pkg::IDX_UY] = ucy_reg;
        lane_c2[obfn_pkg::IDX_UZ] = ucz_reg;
        lane_c2[obfn_pkg::IDX_VX] = PW'(vcx4_reg);
        lane_c2[obfn_pkg::IDX_VY] = PW'(vcy4_reg);
        lane_c2[obfn_pkg::IDX_VZ] = PW'(vcz4_reg);
        lane_c2[obfn_pkg::IDX_WX] = PW'(wcx4_reg);
        lane_c2[obfn_pkg::IDX_WY] = PW'(wcy4_reg);
        lane_c2[obfn_pkg::IDX_WZ] = PW'(wcz4_reg);
        lane_d[obfn_pkg::IDX_UX]  = du_reg;
        lane_d[obfn_pkg::IDX_UY]  = du_reg;
        lane_d[obfn_pkg::IDX_UZ]  = du_reg;
        lane_d[obfn_pkg::IDX_VX]  = PW'(s24_reg);
        lane_d[obfn_pkg::IDX_VY]  = PW'(s24_reg);
        lane_d[obfn_pkg::IDX_VZ]  = PW'(s24_reg);
        lane_d[obfn_pkg::IDX_WX]  = PW'(s4_reg);
        lane_d[obfn_pkg::IDX_WY]  = PW'(s4_reg);
        lane_d[obfn_pkg::IDX_WZ]  = PW'(s4_reg);
    end

    genvar g;
    generate
        for (g = 0; g < NO; g++)
        begin : g_lane
            obfn_root #(
                .FRAC_BITS (FRAC_BITS)
            ) u_root (
                .clk   (clk),
                .en    (adv),
                .c2_sq (lane_c2[g]),
                .dvs   (lane_d[g]),
                .m_out (lane_m[g])
            );
        end
    endgenerate

    // round half up, apply sign, clear on zero normal
    always_comb
    begin
        logic [QW-1:0]    rnd;
        logic [QW-1:0]    val;
        logic [QW+OW-1:0] ext;
        for (int i = 0; i < NO; i++)
        begin
            rnd = ({1'b0, lane_m[i]} + QW'(1)) >> 1;
            val = dly_sgn_reg[NS-1][i] ? (QW'(0) - rnd) : rnd;
            ext = {{OW{val[QW-1]}}, val};
            tail[i] = dly_zero_reg[NS-1] ? '0 : ext[OW-1:0];
        end
    end

    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg  <= skid_vld_reg || dly_vld_reg[NS-1];
            skid_vld_reg <= 1'b0;
        end
        else if (dly_vld_reg[NS-1])
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            res_reg      <= skid_vld_reg ? skid_reg : tail;
            res_zero_reg <= skid_vld_reg ? skid_zero_reg : dly_zero_reg[NS-1];
        end
        else if (adv)
        begin
            skid_reg      <= tail;
            skid_zero_reg <= dly_zero_reg[NS-1];
        end
    end

    assign out_valid   = out_vld_reg;
    assign u_x         = res_reg[obfn_pkg::IDX_UX];
    assign u_y         = res_reg[obfn_pkg::IDX_UY];
    assign u_z         = res_reg[obfn_pkg::IDX_UZ];
    assign v_x         = res_reg[obfn_pkg::IDX_VX];
    assign v_y         = res_reg[obfn_pkg::IDX_VY];
    assign v_z         = res_reg[obfn_pkg::IDX_VZ];
    assign w_x         = res_reg[obfn_pkg::IDX_WX];
    assign w_y         = res_reg[obfn_pkg::IDX_WY];
    assign w_z         = res_reg[obfn_pkg::IDX_WZ];
    assign zero_normal = res_zero_reg;

endmodule

FILE: hdl/obfn_root.sv
// pipelined digit-recurrence lane: largest m with m*m*d <= c2 * 4^(frac_bits+1)
`timescale 1ns / 1ps

module obfn_root #(
    parameter int FRAC_BITS = 14
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [obfn_pkg::PROD_W-1:0] c2_sq,
    input  logic [obfn_pkg::PROD_W-1:0] dvs,
    output logic [FRAC_BITS+1:0]        m_out
);

    localparam int NS = FRAC_BITS + 2;
    localparam int WW = 2 * FRAC_BITS + 68;

    logic [WW-1:0] r_reg  [NS-1];
    logic [WW-1:0] md_reg [NS-1];
    logic [WW-1:0] d_reg  [NS-1];
    logic [NS-1:0] m_reg  [NS];

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_stage
            localparam int K = NS - 1 - j;
            logic [WW-1:0] r_cur;
            logic [WW-1:0] md_cur;
            logic [WW-1:0] d_cur;
            logic [NS-1:0] m_cur;
            logic [WW-1:0] t;
            logic          take;

            if (j == 0)
            begin : g_first
                assign r_cur  = WW'(c2_sq) << (2 * FRAC_BITS + 2);
                assign md_cur = '0;
                assign d_cur  = WW'(dvs);
                assign m_cur  = '0;
            end
            else
            begin : g_next
                assign r_cur  = r_reg[j-1];
                assign md_cur = md_reg[j-1];
                assign d_cur  = d_reg[j-1];
                assign m_cur  = m_reg[j-1];
            end

            // trial (m + 2^k)^2 d - m^2 d
            assign t    = (md_cur << (K + 1)) + (d_cur << (2 * K));
            assign take = (t <= r_cur);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[j] <= take ? (m_cur | (NS'(1) << K)) : m_cur;
                end
            end

            if (j < NS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        r_reg[j]  <= take ? (r_cur - t) : r_cur;
                        md_reg[j] <= take ? (md_cur + (d_cur << K)) : md_cur;
                        d_reg[j]  <= d_cur;
                    end
                end
            end
        end
    endgenerate

    assign m_out = m_reg[NS-1];

endmodule

FILE: hdl/obfn_check.sv
// port checker for the orthonormal basis block, bound to the top level
`timescale 1ns / 1ps

module obfn_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic signed [15:0] u_x,
    input logic signed [15:0] u_y,
    input logic signed [15:0] u_z,
    input logic signed [15:0] v_x,
    input logic signed [15:0] v_y,
    input logic signed [15:0] v_z,
    input logic signed [15:0] w_x,
    input logic signed [15:0] w_y,
    input logic signed [15:0] w_z,
    input logic        zero_normal
);

    // stalled transfer stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped under stall");

    // input side only backs up behind a waiting result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall with no pending result");

    // zero normal gives an all-zero frame
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_normal |-> u_x == 0 && u_y == 0 && u_z == 0 &&
        v_x == 0 && v_y == 0 && v_z == 0 && w_x == 0 && w_y == 0 && w_z == 0)
        else $error("nonzero frame for zero normal");

    // v is built from a cross product with a unit axis
    a_v_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> v_x == 0 || v_y == 0)
        else $error("v has both x and y set");

endmodule

bind orthonormal_basis_from_normal obfn_check u_obfn_check (.*);
